// ===== rtl/roqt_pkg.sv =====
// Shared constants and types for the rectangle overlap query table.
package roqt_pkg;

  localparam int TableEntries = 64;
  localparam int IgnoreSlots  = 8;
  localparam int SlotW        = $clog2(TableEntries);
  localparam int SkipW        = $clog2(IgnoreSlots + 1);
  localparam int SkipIdxW     = (IgnoreSlots > 1) ? $clog2(IgnoreSlots) : 1;

  // Stored entry: kind, ident, x, y, w, h
  localparam int EntryW = 2 + 16 + 16 + 16 + 15 + 15;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_IGNORE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_HIT     = 3'd3,
    ST_NO_HIT  = 3'd4
  } status_t;

  localparam logic [1:0] KindInvalid = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        ident;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } entry_t;

endpackage

// ===== rtl/roqt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module roqt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rect_overlap_query_table.sv =====
// Top level: rectangle table with insert, delete, ignore list and overlap query.
// Insert, delete and query scan all TableEntries slots, one per cycle, before the
// result is given; add-ignore answers in the cycle after accept. One item is in work
// at a time; the next item can be taken in the cycle after the result is taken.
// Reset clears valid bits and the ignore count at once; there is no clearing pass.
module rect_overlap_query_table
  import roqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [1:0]  kind,
  input  logic [15:0] ident,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [14:0] width,
  input  logic [14:0] height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] hit_ident,
  output logic [1:0]  hit_kind
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_OUT} state_t;

  state_t state;
  logic [TableEntries-1:0] slot_valid;
  logic [SkipW-1:0]        skip_count;
  logic [15:0]             skip_ids [IgnoreSlots];

  // latched item
  op_t         cur_op;
  entry_t      cur;
  logic [SlotW:0] raddr_cnt;   // next slot to read
  logic [SlotW-1:0] chk_slot;  // slot whose data is on rdata
  logic        chk_live;
  logic        dup, have_free, found;
  logic [SlotW-1:0] free_slot;
  logic [17:0] best_key;

  // slot memory
  logic        ram_we;
  logic [SlotW-1:0] ram_waddr;
  entry_t      ram_rd;
  logic [EntryW-1:0] ram_rdata;

  roqt_ram #(.Width(EntryW), .Depth(TableEntries)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur),
    .raddr (raddr_cnt[SlotW-1:0]),
    .rdata (ram_rdata)
  );
  assign ram_rd = entry_t'(ram_rdata);

  assign in_ready = (state == S_IDLE);

  // per-slot test on read data
  logic        v_slot, skipped, overlap, key_match;
  logic signed [16:0] ax_end, ay_end, bx_end, by_end;
  logic [17:0] key;
  always_comb begin
    v_slot    = chk_live && slot_valid[chk_slot];
    key_match = (ram_rd.kind == cur.kind) && (ram_rd.ident == cur.ident);
    ax_end = 17'(ram_rd.x) + $signed({2'b0, ram_rd.w});
    ay_end = 17'(ram_rd.y) + $signed({2'b0, ram_rd.h});
    bx_end = 17'(cur.x) + $signed({2'b0, cur.w});
    by_end = 17'(cur.y) + $signed({2'b0, cur.h});
    overlap = !(ax_end < 17'(cur.x)) && !(bx_end < 17'(ram_rd.x)) &&
              !(ay_end < 17'(cur.y)) && !(by_end < 17'(ram_rd.y));
    skipped = 1'b0;
    for (int i = 0; i < IgnoreSlots; i++) begin
      if ((SkipW'(i) < skip_count) && (skip_ids[i] == ram_rd.ident)) skipped = 1'b1;
    end
    key = {ram_rd.kind, ram_rd.ident};
  end

  // control
  always_ff @(posedge clk) begin
    ram_we <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      skip_count <= '0;
      out_valid  <= 1'b0;
      chk_live   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_op    <= op_t'(op);
            cur       <= '{kind, ident, pos_x, pos_y, width, height};
            raddr_cnt <= '0;
            chk_live  <= 1'b0;
            dup       <= 1'b0;
            have_free <= 1'b0;
            found     <= 1'b0;
            if (op_t'(op) == OP_IGNORE) begin
              if (skip_count < SkipW'(IgnoreSlots)) begin
                skip_ids[skip_count[SkipIdxW-1:0]] <= ident;
                skip_count <= skip_count + 1'b1;
              end
              status    <= ST_DONE;
              hit_ident <= '0;
              hit_kind  <= '0;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN, S_FINISH: begin
          // issue next read
          if (raddr_cnt != (SlotW+1)'(TableEntries)) begin
            raddr_cnt <= raddr_cnt + 1'b1;
          end
          chk_live <= (raddr_cnt != (SlotW+1)'(TableEntries));
          chk_slot <= raddr_cnt[SlotW-1:0];
          // evaluate slot on rdata
          if (chk_live) begin
            if (!slot_valid[chk_slot]) begin
              if (!have_free) begin
                have_free <= 1'b1;
                free_slot <= chk_slot;
              end
            end
            unique case (cur_op)
              OP_INSERT: if (v_slot && key_match) dup <= 1'b1;
              OP_DELETE: if (v_slot && key_match) slot_valid[chk_slot] <= 1'b0;
              default: begin
                if (v_slot && ram_rd.ident != cur.ident && overlap && !skipped &&
                    (!found || key < best_key)) begin
                  found    <= 1'b1;
                  best_key <= key;
                end
              end
            endcase
          end
          if (state == S_SCAN && !chk_live && raddr_cnt == (SlotW+1)'(TableEntries)) begin
            state <= S_FINISH;
          end
          if (state == S_FINISH) begin
            status    <= ST_DONE;
            hit_ident <= '0;
            hit_kind  <= '0;
            unique case (cur_op)
              OP_INSERT: begin
                if (cur.kind != KindInvalid) begin
                  if (dup) status <= ST_DUP;
                  else if (!have_free) status <= ST_FULL;
                  else begin
                    slot_valid[free_slot] <= 1'b1;
                    ram_we    <= 1'b1;
                    ram_waddr <= free_slot;
                  end
                end
              end
              OP_QUERY: begin
                skip_count <= '0;
                if (found) begin
                  status    <= ST_HIT;
                  hit_ident <= best_key[15:0];
                  hit_kind  <= best_key[17:16];
                end else begin
                  status <= ST_NO_HIT;
                end
              end
              default: ;
            endcase
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/rect_overlap_query_table_test.sv =====
// Testbench for the rectangle overlap query table: directed and random items checked
// against a behavioral table model.
module rect_overlap_query_table_test;
  import roqt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] hit_ident;
    logic [1:0]  hit_kind;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = '0;
  logic [1:0]  kind = '0;
  logic [15:0] ident = '0;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;
  logic [14:0] width = '0;
  logic [14:0] height = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] hit_ident;
  logic [1:0]  hit_kind;

  // model state of the table and ignore list
  bit          tbl_used [TableEntries];
  logic [1:0]  tbl_kind [TableEntries];
  logic [15:0] tbl_ident [TableEntries];
  int          tbl_x [TableEntries];
  int          tbl_y [TableEntries];
  int          tbl_w [TableEntries];
  int          tbl_h [TableEntries];
  logic [15:0] skip_list [IgnoreSlots];
  int          skip_len;

  answer_t     pending_answers[$];
  int          errors;
  int          items_sent;
  int          answers_seen;
  int          hits_seen;
  int          full_seen;
  int          idle_cycles;
  int          hold_off;

  rect_overlap_query_table DUT (.*);

  always #6 clk = ~clk;

  // compute the expected answer for one item and update the model
  function automatic answer_t table_answer(logic [1:0] o, logic [1:0] k, logic [15:0] id,
                                           logic [15:0] x, logic [15:0] y,
                                           logic [14:0] w, logic [14:0] h);
    answer_t a;
    int free_i;
    bit dup;
    bit found;
    bit skip;
    logic [17:0] best;
    logic [17:0] key;
    int qx;
    int qy;
    a = '{ST_DONE, 16'd0, 2'd0};
    free_i = -1;
    dup = 0;
    found = 0;
    best = '0;
    qx = int'($signed(x));
    qy = int'($signed(y));
    case (op_t'(o))
      OP_INSERT: begin
        if (k != KindInvalid) begin
          for (int i = 0; i < TableEntries; i++) begin
            if (tbl_used[i]) begin
              if (tbl_kind[i] == k && tbl_ident[i] == id) dup = 1;
            end else if (free_i < 0) begin
              free_i = i;
            end
          end
          if (dup) a.status = ST_DUP;
          else if (free_i < 0) a.status = ST_FULL;
          else begin
            tbl_used[free_i] = 1;
            tbl_kind[free_i] = k;
            tbl_ident[free_i] = id;
            tbl_x[free_i] = qx;
            tbl_y[free_i] = qy;
            tbl_w[free_i] = int'(w);
            tbl_h[free_i] = int'(h);
          end
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < TableEntries; i++)
          if (tbl_used[i] && tbl_kind[i] == k && tbl_ident[i] == id) tbl_used[i] = 0;
      end
      OP_IGNORE: begin
        if (skip_len < IgnoreSlots) begin
          skip_list[skip_len] = id;
          skip_len++;
        end
      end
      default: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (!tbl_used[i] || tbl_ident[i] == id) continue;
          if (tbl_x[i] + tbl_w[i] < qx || qx + int'(w) < tbl_x[i]) continue;
          if (tbl_y[i] + tbl_h[i] < qy || qy + int'(h) < tbl_y[i]) continue;
          skip = 0;
          for (int j = 0; j < skip_len; j++)
            if (skip_list[j] == tbl_ident[i]) skip = 1;
          if (skip) continue;
          key = {tbl_kind[i], tbl_ident[i]};
          if (!found || key < best) begin
            found = 1;
            best = key;
          end
        end
        if (found) begin
          a.status = ST_HIT;
          a.hit_ident = best[15:0];
          a.hit_kind = best[17:16];
        end else begin
          a.status = ST_NO_HIT;
        end
        skip_len = 0;
      end
    endcase
    return a;
  endfunction

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(logic [1:0] o, logic [1:0] k, logic [15:0] id,
                           logic [15:0] x, logic [15:0] y,
                           logic [14:0] w, logic [14:0] h, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op <= o;
    kind <= k;
    ident <= id;
    pos_x <= x;
    pos_y <= y;
    width <= w;
    height <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(table_answer(o, k, id, x, y, w, h));
    items_sent++;
    @(negedge clk);
  endtask

  // wait until every answer has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // random item, mostly near a small window so rectangles meet
  task automatic send_random(int id_span);
    logic [1:0] o;
    logic [15:0] x;
    logic [15:0] y;
    o = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else begin
      x = 16'($signed($urandom_range(0, 400)) - 200);
      y = 16'($signed($urandom_range(0, 400)) - 200);
    end
    send_item(o, 2'($urandom_range(0, 3)), 16'($urandom_range(0, id_span)), x, y,
              ($urandom_range(0, 15) == 0) ? 15'($urandom) : 15'($urandom_range(0, 120)),
              ($urandom_range(0, 15) == 0) ? 15'($urandom) : 15'($urandom_range(0, 120)));
  endtask

  // receiver: random wait before each item, plus one long hold-off
  always begin
    int wait_cycles;
    wait_cycles = $urandom_range(0, 13);
    if (wait_cycles > 0 || hold_off > 0) begin
      out_ready <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
      while (hold_off > 0) begin
        @(negedge clk);
        hold_off--;
      end
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!out_valid);
    @(negedge clk);
  end

  // checker of each accepted answer
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("answer with no item outstanding");
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (e.status == ST_HIT) hits_seen++;
        if (e.status == ST_FULL) full_seen++;
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (hit_ident !== e.hit_ident) begin
          $error("hit_ident expected %0d actual %0d", e.hit_ident, hit_ident);
          errors++;
        end
        if (hit_kind !== e.hit_kind) begin
          $error("hit_kind expected %0d actual %0d", e.hit_kind, hit_kind);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // edge cases: extreme fields, touching edges, kind three, absent delete
  task automatic test_directed();
    send_item(OP_INSERT, 2'd0, 16'd5, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
    send_item(OP_INSERT, 2'd0, 16'd5, 16'd0, 16'd0, 15'd1, 15'd1);
    send_item(OP_INSERT, 2'd3, 16'd9, 16'd0, 16'd0, 15'd1, 15'd1);
    send_item(OP_DELETE, 2'd3, 16'd5, 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(OP_INSERT, 2'd2, 16'hffff, 16'h7fff, 16'h7fff, 15'd0, 15'd0);
    send_item(OP_INSERT, 2'd1, 16'd0, 16'd100, 16'd100, 15'd10, 15'd10);
    send_item(OP_QUERY, 2'd3, 16'd1, 16'd110, 16'd110, 15'd0, 15'd0);
    send_item(OP_QUERY, 2'd0, 16'd1, 16'd111, 16'd100, 15'd0, 15'd0);
    send_item(OP_QUERY, 2'd0, 16'd7, 16'h7fff, 16'h7fff, 15'd0, 15'd0);
    send_item(OP_IGNORE, 2'd0, 16'd5, 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(OP_QUERY, 2'd1, 16'd5, 16'd100, 16'd100, 15'd0, 15'd0);
    send_item(OP_QUERY, 2'd1, 16'd0, 16'd100, 16'd100, 15'd0, 15'd0);
    for (int i = 0; i < IgnoreSlots + 2; i++)
      send_item(OP_IGNORE, 2'd0, 16'(i), 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(OP_QUERY, 2'd0, 16'd99, 16'd100, 16'd100, 15'd5, 15'd5);
    send_item(OP_DELETE, 2'd2, 16'd1234, 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(OP_DELETE, 2'd0, 16'd5, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff);
    drain();
  endtask

  // fill the table until it reports full, with a long receiver stall
  task automatic test_full_table();
    hold_off = 400;
    for (int i = 0; i < TableEntries + 3; i++)
      send_item(OP_INSERT, 2'($urandom_range(0, 2)), 16'(1000 + i),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                15'($urandom_range(0, 60)), 15'($urandom_range(0, 60)), 1);
    repeat (6) send_item(OP_QUERY, 2'd0, 16'($urandom_range(1000, 1070)),
                         16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                         15'($urandom_range(0, 40)), 15'($urandom_range(0, 40)));
    for (int i = 0; i < TableEntries + 3; i++)
      send_item(OP_DELETE, tbl_kind[i % TableEntries], 16'(1000 + i),
                16'd0, 16'd0, 15'd0, 15'd0);
    drain();
  endtask

  // random traffic over narrow and wide id ranges
  task automatic test_random();
    repeat (1100) send_random(40);
    repeat (350) send_random(65535);
    drain();
  endtask

  initial begin
    errors = 0;
    skip_len = 0;
    hold_off = 0;
    idle_cycles = 0;
    for (int i = 0; i < TableEntries; i++) tbl_used[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random();
    $display("Covered %0d items, %0d answers, %0d hits, %0d table-full answers.",
             items_sent, answers_seen, hits_seen, full_seen);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/roqt_pkg.sv
rtl/roqt_ram.sv
rtl/rect_overlap_query_table.sv
tb/rect_overlap_query_table_test.sv
